[rtl/ascii_length_prefixed_deframer_defines.svh]
// Assertion macros for the ASCII length-prefixed deframer checker.
// Needs nothing but a clock and an active-low reset in the using scope.
`ifndef ASCII_LENGTH_PREFIXED_DEFRAMER_DEFINES_SVH
`define ASCII_LENGTH_PREFIXED_DEFRAMER_DEFINES_SVH

// Property checked only while reset is released.
`define ALPD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("alpd checker: property failed");

// Property checked on every edge, reset included.
`define ALPD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("alpd checker: property failed");

`endif

[rtl/alpd_pkg.sv]
// Shared types and constants for the ASCII length-prefixed deframer.
// No dependencies; the RTL modules and the checker refer to it by scoped names.
`default_nettype none

package alpd_pkg;

  localparam int LENGTH_DIGITS = 4;
  localparam int DIGIT_W       = 3;
  localparam int LEN_W         = 14;
  localparam int BYTE_W        = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 14;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 14'd512;
  localparam logic [BYTE_W-1:0] HEAD_BYTE_RST  = 8'd0;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd1;

  typedef enum logic [1:0] {
    ST_PAYLOAD  = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERSIZE = 2'd2,
    ST_BADLEN   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_PASS = 4'b0100,
    PH_DROP = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_last;
    status_t           status;
  } res_t;

  // One step's outcome: whether the byte produces a result, and that result.
  typedef struct packed {
    logic valid;
    res_t res;
  } step_t;

endpackage

`default_nettype wire

[rtl/alpd_if.sv]
// Valid/ready channel interfaces for the deframer: raw byte beats in, result beats out.
// Depends on nothing.
`default_nettype none

interface alpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface alpd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       frame_last;
  logic [1:0] status;

  modport source (output valid, output payload_byte, output frame_last, output status,
                  input ready);
  modport sink   (input valid, input payload_byte, input frame_last, input status,
                  output ready);
endinterface

`default_nettype wire

[rtl/ascii_length_prefixed_deframer.sv]
// A byte is held in the input register, then its result beat is loaded into the result register.
// Throughput: one byte beat per cycle while the sink keeps up; a held byte that makes no
// result is processed even while an older result beat waits.
// The rate is set by the single state update between the input and result registers.
// Reset (rst_n low, synchronous) returns to hunting, empties both registers and
// restores head_byte to 0 and max_payload to 512; no clearing pass follows.
`default_nettype none

module ascii_length_prefixed_deframer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  alpd_byte_if.sink                            in_ch,
  alpd_res_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [alpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [alpd_pkg::CFG_DATA_W-1:0] cfg_data
);

  // The block is a three-part pipeline. The input stage holds one raw byte.
  // The state machine turns that byte, together with the frame state, into
  // the next state and at most one result. The output stage holds a result
  // beat until the sink takes it, so a new byte can be accepted while an
  // older result still waits.

  logic                        s0_valid;
  logic [alpd_pkg::BYTE_W-1:0] s0_byte;
  logic                        adv;
  logic                        can_load;
  logic                        out_valid;
  alpd_pkg::step_t             step;
  alpd_pkg::res_t              res_out;

  alpd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.data_byte),
    .in_ready (in_ch.ready),
    .adv      (adv),
    .s0_valid (s0_valid),
    .s0_byte  (s0_byte)
  );

  alpd_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .data_byte (s0_byte),
    .adv       (adv),
    .step      (step)
  );

  // The held byte is processed when it makes no result, or when the result
  // register is free or being emptied in this same cycle.
  assign adv = s0_valid && (!step.valid || can_load);

  alpd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && step.valid),
    .res_in    (step.res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .res_out   (res_out)
  );

  assign out_ch.valid        = out_valid;
  assign out_ch.payload_byte = res_out.payload_byte;
  assign out_ch.frame_last   = res_out.frame_last;
  assign out_ch.status       = res_out.status;

endmodule

`default_nettype wire

[rtl/alpd_in_stage.sv]
// Input register of the deframer: holds one accepted byte until the state update takes it.
// Depends on alpd_pkg.
`default_nettype none

module alpd_in_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [alpd_pkg::BYTE_W-1:0] in_byte,
  output      logic                        in_ready,
  input  wire logic                        adv,
  output      logic                        s0_valid,
  output      logic [alpd_pkg::BYTE_W-1:0] s0_byte
);

  logic                        s0_v_r;
  logic                        s0_v_nxt;
  logic [alpd_pkg::BYTE_W-1:0] s0_byte_r;

  // A new beat may enter when the register is empty or is emptied this cycle.
  assign in_ready = !s0_v_r || adv;

  always_comb begin
    s0_v_nxt = s0_v_r;
    if (in_valid && in_ready) begin
      s0_v_nxt = 1'b1;
    end else if (adv) begin
      s0_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= s0_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_byte_r <= in_byte;
    end
  end

  assign s0_valid = s0_v_r;
  assign s0_byte  = s0_byte_r;

endmodule

`default_nettype wire

[rtl/alpd_fsm.sv]
// Deframing state machine and configuration registers; computes one step per byte.
// Depends on alpd_pkg.
`default_nettype none

module alpd_fsm (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [alpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [alpd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [alpd_pkg::BYTE_W-1:0]     data_byte,
  input  wire logic                            adv,
  output      alpd_pkg::step_t                 step
);

  logic [alpd_pkg::BYTE_W-1:0] head_byte_r;
  logic [alpd_pkg::LEN_W-1:0]  max_payload_r;

  alpd_pkg::phase_t             phase_r, phase_nxt;
  logic [alpd_pkg::DIGIT_W-1:0] digits_r, digits_nxt;
  logic [alpd_pkg::LEN_W-1:0]   flen_r, flen_nxt;
  logic [alpd_pkg::LEN_W-1:0]   left_r, left_nxt;

  logic [alpd_pkg::LEN_W-1:0] flen_acc;
  logic [alpd_pkg::LEN_W-1:0] left_dec;
  logic                       is_digit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_byte_r   <= alpd_pkg::HEAD_BYTE_RST;
      max_payload_r <= alpd_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      if (cfg_index == alpd_pkg::CFG_HEAD_BYTE) begin
        head_byte_r <= cfg_data[alpd_pkg::BYTE_W-1:0];
      end else if (cfg_index == alpd_pkg::CFG_MAX_PAYLOAD) begin
        max_payload_r <= cfg_data[alpd_pkg::LEN_W-1:0];
      end
    end
  end

  // For an ASCII digit the low nibble is its value; times ten is two shifts and an add.
  assign is_digit = data_byte inside {[8'h30:8'h39]};
  assign flen_acc = (flen_r << 3) + (flen_r << 1)
                  + {{(alpd_pkg::LEN_W-4){1'b0}}, data_byte[3:0]};
  assign left_dec = left_r - 14'd1;

  always_comb begin
    phase_nxt               = phase_r;
    digits_nxt              = digits_r;
    flen_nxt                = flen_r;
    left_nxt                = left_r;
    step.valid              = 1'b0;
    step.res.payload_byte   = '0;
    step.res.frame_last     = 1'b0;
    step.res.status         = alpd_pkg::ST_PAYLOAD;
    case (phase_r)
      alpd_pkg::PH_HUNT: begin
        if (data_byte == head_byte_r) begin
          phase_nxt  = alpd_pkg::PH_LEN;
          digits_nxt = '0;
          flen_nxt   = '0;
        end
      end
      alpd_pkg::PH_LEN: begin
        if (!is_digit) begin
          phase_nxt           = alpd_pkg::PH_HUNT;
          digits_nxt          = '0;
          flen_nxt            = '0;
          step.valid          = 1'b1;
          step.res.frame_last = 1'b1;
          step.res.status     = alpd_pkg::ST_BADLEN;
        end else begin
          flen_nxt = flen_acc;
          if (digits_r == alpd_pkg::DIGIT_W'(alpd_pkg::LENGTH_DIGITS - 1)) begin
            digits_nxt = '0;
            if (flen_acc == '0) begin
              phase_nxt           = alpd_pkg::PH_HUNT;
              step.valid          = 1'b1;
              step.res.frame_last = 1'b1;
              step.res.status     = alpd_pkg::ST_EMPTY;
            end else begin
              left_nxt  = flen_acc;
              phase_nxt = (flen_acc > max_payload_r) ? alpd_pkg::PH_DROP
                                                     : alpd_pkg::PH_PASS;
            end
          end else begin
            digits_nxt = digits_r + 3'd1;
          end
        end
      end
      alpd_pkg::PH_PASS: begin
        left_nxt              = left_dec;
        step.valid            = 1'b1;
        step.res.payload_byte = data_byte;
        if (left_dec == '0) begin
          phase_nxt           = alpd_pkg::PH_HUNT;
          flen_nxt            = '0;
          step.res.frame_last = 1'b1;
        end
      end
      alpd_pkg::PH_DROP: begin
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt           = alpd_pkg::PH_HUNT;
          flen_nxt            = '0;
          step.valid          = 1'b1;
          step.res.frame_last = 1'b1;
          step.res.status     = alpd_pkg::ST_OVERSIZE;
        end
      end
      default: begin
        phase_nxt = alpd_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= alpd_pkg::PH_HUNT;
      digits_r <= '0;
      flen_r   <= '0;
      left_r   <= '0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      digits_r <= digits_nxt;
      flen_r   <= flen_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/alpd_out_stage.sv]
// Result register of the deframer: holds one result beat until the sink takes it.
// Depends on alpd_pkg.
`default_nettype none

module alpd_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire alpd_pkg::res_t res_in,
  output      logic          can_load,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      alpd_pkg::res_t res_out
);

  logic           out_v_r;
  logic           out_v_nxt;
  alpd_pkg::res_t res_r;

  assign can_load = !out_v_r || out_ready;

  always_comb begin
    out_v_nxt = out_v_r;
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = out_v_r;
  assign res_out   = res_r;

endmodule

`default_nettype wire

[rtl/alpd_checker.sv]
// Port-level checker for the deframer and the bind that attaches it to the top level.
// Depends on alpd_pkg and the assertion macros header.
`default_nettype none
`include "ascii_length_prefixed_deframer_defines.svh"

module alpd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_payload_byte,
  input wire logic       out_frame_last,
  input wire logic [1:0] out_status
);

  `ALPD_ASSERT(a_valid_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `ALPD_ASSERT(a_payload_hold, clk, rst_n, out_valid && !out_ready |=> $stable({out_payload_byte, out_frame_last, out_status}))
  `ALPD_ASSERT(a_flag_shape, clk, rst_n, out_valid && out_status != alpd_pkg::ST_PAYLOAD |-> out_frame_last && out_payload_byte == 8'd0)
  `ALPD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind ascii_length_prefixed_deframer alpd_checker u_alpd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_payload_byte (out_ch.payload_byte),
  .out_frame_last   (out_ch.frame_last),
  .out_status       (out_ch.status)
);

`default_nettype wire

[dv/alpd_deframe_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the ASCII length-prefixed deframer: predicts result beats from accepted
// byte beats and register writes, and compares them with the result channel.
// Depends on alpd_pkg for widths, register indexes and the status codes.

module alpd_deframe_checker
  import alpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [BYTE_W-1:0]     out_payload,
  input  logic                  out_last,
  input  logic [1:0]            out_status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    beats_owed,
  output int                    n_payload,
  output int                    n_empty,
  output int                    n_oversize,
  output int                    n_badlen
);

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

  // Mirror of the register file and of the framing state.
  logic [BYTE_W-1:0] head_cfg;
  logic [LEN_W-1:0]  max_cfg;
  phase_t            ph;
  logic [DIGIT_W-1:0] ndig;
  logic [LEN_W-1:0]  acc_len;
  logic [LEN_W-1:0]  remaining;

  res_t deframed_q[$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Advances the framing state by one byte; returns 1 when the byte yields a result beat.
  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output res_t r);
    r.payload_byte = '0;
    r.frame_last   = 1'b1;
    r.status       = ST_PAYLOAD;
    case (ph)
      PH_HUNT: begin
        if (b == head_cfg) begin
          ph      = PH_LEN;
          ndig    = '0;
          acc_len = '0;
        end
        return 1'b0;
      end
      PH_LEN: begin
        if (b < ASCII_ZERO || b > ASCII_NINE) begin
          ph       = PH_HUNT;
          ndig     = '0;
          acc_len  = '0;
          r.status = ST_BADLEN;
          return 1'b1;
        end
        acc_len = acc_len * 14'd10 + LEN_W'(b - ASCII_ZERO);
        ndig    = ndig + 1'b1;
        if (ndig < LENGTH_DIGITS) return 1'b0;
        ndig = '0;
        if (acc_len == '0) begin
          ph       = PH_HUNT;
          r.status = ST_EMPTY;
          return 1'b1;
        end
        remaining = acc_len;
        ph        = (acc_len > max_cfg) ? PH_DROP : PH_PASS;
        return 1'b0;
      end
      PH_PASS: begin
        remaining      = remaining - 1'b1;
        r.payload_byte = b;
        r.frame_last   = (remaining == '0);
        if (remaining == '0) begin
          ph      = PH_HUNT;
          acc_len = '0;
        end
        return 1'b1;
      end
      default: begin
        remaining = remaining - 1'b1;
        if (remaining != '0) return 1'b0;
        ph       = PH_HUNT;
        acc_len  = '0;
        r.status = ST_OVERSIZE;
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    res_t predicted;
    if (!rst_n) begin
      head_cfg  = HEAD_BYTE_RST;
      max_cfg   = MAX_PAYLOAD_RST;
      ph        = PH_HUNT;
      ndig      = '0;
      acc_len   = '0;
      remaining = '0;
      deframed_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.payload_byte = out_payload;
        got.frame_last   = out_last;
        got.status       = status_t'(out_status);
        if (deframed_q.size() == 0) begin
          report_mismatch($sformatf("result beat %h/%b/%s with nothing expected",
                                    got.payload_byte, got.frame_last, got.status.name()));
        end else begin
          want = deframed_q.pop_front();
          if (got.payload_byte !== want.payload_byte)
            report_mismatch($sformatf("payload_byte got %h want %h",
                                      got.payload_byte, want.payload_byte));
          if (got.frame_last !== want.frame_last)
            report_mismatch($sformatf("frame_last got %b want %b",
                                      got.frame_last, want.frame_last));
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %s want %s",
                                      got.status.name(), want.status.name()));
          case (want.status)
            ST_PAYLOAD:  n_payload++;
            ST_EMPTY:    n_empty++;
            ST_OVERSIZE: n_oversize++;
            default:     n_badlen++;
          endcase
        end
      end
      // The byte at this edge still sees the old registers; a write counts from the next one.
      if (in_valid && in_ready) begin
        if (deframe_byte(in_data, predicted)) deframed_q.push_back(predicted);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEAD_BYTE:   head_cfg = cfg_data[BYTE_W-1:0];
          CFG_MAX_PAYLOAD: max_cfg  = cfg_data;
          default: ;
        endcase
      end
    end
    beats_owed = deframed_q.size();
  end

endmodule

[dv/tb_ascii_length_prefixed_deframer.sv]
`timescale 1ns / 100ps
// Top of the deframer testbench: clock, reset, byte and register stimulus, and the verdict.
// Depends on alpd_pkg, the channel interfaces in alpd_if.sv and alpd_deframe_checker.

module tb_ascii_length_prefixed_deframer;
  import alpd_pkg::*;

  localparam logic [BYTE_W-1:0]    ASCII_ZERO       = 8'h30;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 2'd3;
  // Number of random bytes per register setting, toward roughly 2000 overall.
  localparam int PHASE_BEATS  = 340;
  localparam int NUM_PHASES   = 6;
  // Extra idle cycles after the last predicted beat let any byte still in flight pass through.
  localparam int DRAIN_CYCLES = 4;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  alpd_byte_if byte_ch ();
  alpd_res_if  res_ch ();

  int fail_count;
  int beats_owed;
  int n_payload;
  int n_empty;
  int n_oversize;
  int n_badlen;

  // Idle rates in percent, changed between phases.
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int bytes_sent     = 0;
  // At most one long frame per run, so that a four-digit length is seen now and then
  // without inflating the byte count much.
  int big_left       = 1;

  ascii_length_prefixed_deframer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (byte_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  alpd_deframe_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (byte_ch.valid),
    .in_ready    (byte_ch.ready),
    .in_data     (byte_ch.data_byte),
    .out_valid   (res_ch.valid),
    .out_ready   (res_ch.ready),
    .out_payload (res_ch.payload_byte),
    .out_last    (res_ch.frame_last),
    .out_status  (res_ch.status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .beats_owed  (beats_owed),
    .n_payload   (n_payload),
    .n_empty     (n_empty),
    .n_oversize  (n_oversize),
    .n_badlen    (n_badlen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver drops ready at random according to the current stall rate.
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Offers one byte beat, possibly after idle cycles, and returns at the edge that takes it.
  // Valid is only lowered during a gap, so back-to-back beats keep it high.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends the length field as ASCII decimal, most significant digit first.
  task automatic send_length(input int len);
    int weight;
    weight = 10 ** (LENGTH_DIGITS - 1);
    while (weight > 0) begin
      send_byte(BYTE_W'(ASCII_ZERO + (len / weight) % 10));
      weight = weight / 10;
    end
  endtask

  // A whole well-formed frame with random payload; now and then the head byte shows up
  // inside the payload, where it must pass as an ordinary byte.
  task automatic send_frame(input logic [BYTE_W-1:0] head, input int len);
    send_byte(head);
    send_length(len);
    repeat (len) begin
      if ($urandom_range(15) == 0) send_byte(head);
      else send_byte(BYTE_W'($urandom_range(255)));
    end
  endtask

  // Drops valid, waits for every predicted beat to arrive, then lets the pipeline empty
  // of bytes that produce no beat before any register is touched.
  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (beats_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high so that writes can follow one another without a gap.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [BYTE_W-1:0] head, input logic [LEN_W-1:0] max_len);
    write_reg(CFG_HEAD_BYTE, CFG_DATA_W'(head));
    write_reg(CFG_MAX_PAYLOAD, max_len);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [BYTE_W-1:0] hd;
    logic [LEN_W-1:0]  mx;
    logic [BYTE_W-1:0] bad;
    int made;
    int pick;
    int ndigits;
    int len;

    rst_n             = 1'b0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    res_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_HEAD_BYTE;
    cfg_data          = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, first on the reset values of the registers: head byte 0,
    // longest payload 512. Noise ahead of the head byte must vanish.
    send_byte(8'h55);
    send_byte(8'hFF);
    // Three payload bytes at the extremes; the middle one equals the head byte.
    send_byte(8'h00);
    send_length(3);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    // A zero length is reported once as an empty frame.
    send_frame(8'h00, 0);
    // Non-digits just past both ends of the digit range abort the length field.
    send_byte(8'h00);
    send_byte("1");
    send_byte(8'h3A);
    send_byte(8'h00);
    send_byte("9");
    send_byte(8'h2F);
    // The head byte inside the length field is only a bad digit, not a new frame.
    send_byte(8'h00);
    send_byte(8'h00);
    settle();

    // A write to an unmapped index must change nothing; then every frame is oversized.
    write_reg(CFG_IDX_UNMAPPED, '1);
    set_config(8'hFF, '0);
    send_frame(8'hFF, 2);
    settle();

    // A head byte that is itself a digit, and the largest allowed limit.
    set_config("7", 14'd9999);
    send_byte("7");
    send_length(1);
    send_byte("7");
    settle();

    // Random part: one register setting and one idle pattern per phase. Most traffic is
    // well-formed frames; the rest is line noise, cut-off length fields and empty frames.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin hd = 8'h7E;                   mx = MAX_PAYLOAD_RST;              end
        1: begin hd = HEAD_BYTE_RST;           mx = '0;                           end
        2: begin hd = 8'hFF;                   mx = 14'd9999;                     end
        3: begin hd = "3";                     mx = 14'd5;                        end
        4: begin hd = BYTE_W'($urandom_range(255)); mx = LEN_W'($urandom_range(9999)); end
        default: begin
          hd = BYTE_W'($urandom_range(255));
          mx = LEN_W'($urandom_range(20));
        end
      endcase
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
        default: begin src_idle_pct = 18; sink_stall_pct = 18; end
      endcase
      set_config(hd, mx);

      made = 0;
      while (made < PHASE_BEATS) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          // Noise between frames; it only counts if it happens to hit the head byte.
          repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(255)));
        end else if (pick < 18) begin
          // Length field broken off by a non-digit after some digits.
          ndigits = $urandom_range(0, LENGTH_DIGITS - 1);
          send_byte(hd);
          repeat (ndigits) send_byte(BYTE_W'(ASCII_ZERO + $urandom_range(9)));
          case ($urandom_range(3))
            0: bad = 8'h2F;
            1: bad = 8'h3A;
            default: begin
              do bad = BYTE_W'($urandom_range(255));
              while (bad >= ASCII_ZERO && bad <= ASCII_ZERO + 8'd9);
            end
          endcase
          send_byte(bad);
          made += ndigits + 2;
        end else if (pick < 22) begin
          send_frame(hd, 0);
          made += LENGTH_DIGITS + 1;
        end else begin
          // Lengths are mostly short, sometimes right at or just past the limit, and
          // very rarely long enough to pass the reset limit or to need four digits.
          if (big_left > 0 && $urandom_range(99) == 0) begin
            len = $urandom_range(13, 1050);
            big_left--;
          end else if (mx <= 64 && $urandom_range(9) == 0) begin
            len = mx + $urandom_range(1);
          end else begin
            len = $urandom_range(1, 12);
          end
          send_frame(hd, len);
          made += LENGTH_DIGITS + 1 + len;
        end
      end
      settle();
    end

    $display("Covered %0d byte beats over %0d register settings and four idle patterns.",
             bytes_sent, NUM_PHASES + 3);
    $display("Result beats: %0d payload, %0d empty, %0d oversized, %0d bad length; %0d errors.",
             n_payload, n_empty, n_oversize, n_badlen, fail_count);
    if (fail_count == 0 && beats_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the rare long frame.
  initial begin
    #8_000_000;
    $display("Timed out with %0d result beats still expected.", beats_owed);
    $display("status: fail");
    $finish;
  end

endmodule
